### hdl/bei_pkg.sv
`default_nettype none
package bei_pkg;

    localparam int MAX_POINTS_DEF = 16;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_EVAL  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]         command;
        logic [31:0]        tick;
        logic signed [15:0] value;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [1:0]         status;
        logic [31:0]        first_tick;
        logic [31:0]        last_tick;
        logic               span_defined;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT,
        S_ENDS_RD,
        S_ENDS_CHK,
        S_EVAL_RD,
        S_EVAL_CHK,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

### hdl/bei_ram.sv
`default_nettype none
module bei_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### hdl/breakpoint_envelope_interpolator_unit.sv
`default_nettype none
// piecewise-linear breakpoint envelope
// command channel: i_start with i_cmd (command, tick, value) is taken when
// o_busy is low; o_busy stays high until the result word is shown
// result channel: o_done strobes for one cycle with o_result; the receiver
// cannot stall, so the result must be taken in that cycle
// config channel: i_cfg_valid/o_cfg_ready writes hold_mode (bit 0); ready
// only while idle
// breakpoints sit in two one-port-read rams (tick, level), sorted by tick
// steps from the accepting edge through the o_done cycle:
//   clear, no-op, evaluate on an empty table: the first and last tick reads
//   add: a read and a check per scan probe, a read and a write per entry
//   moved up, one write, then the first and last tick reads
//   evaluate: a read and a check per probe; when it interpolates, 32 multiply
//   steps and 48 divide steps (shift-add multiplier and restoring divider)
// the next command is taken in the cycle after o_done at the earliest
// the registered ram read sets the scan and shift pace
// reset empties the table and sets hold_mode to 1; ram contents stay
module breakpoint_envelope_interpolator_unit
    import bei_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    input  wire t_in_word  i_cmd,
    output logic           o_busy,
    output logic           o_done,
    output t_out_word      o_result,
    input  wire logic      i_cfg_valid,
    input  wire logic      i_cfg_data,
    output logic           o_cfg_ready
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos, n_pos;
    logic          r_hold;
    t_cmd          r_cmd, n_cmd;
    logic [31:0]   r_tick, n_tick;
    logic signed [15:0] r_val, n_val;
    logic [31:0]   r_t0, n_t0;
    logic signed [15:0] r_y0, n_y0;
    logic [31:0]   r_first, n_first;
    logic [31:0]   r_last, n_last;
    logic signed [15:0] r_sample, n_sample;
    t_status       r_status, n_status;
    logic [47:0]   r_acc, n_acc;
    logic [31:0]   r_mcand, n_mcand;
    logic [47:0]   r_rem, n_rem;
    logic [31:0]   r_dx, n_dx;
    logic          r_neg, n_neg;
    logic [6:0]    r_step, n_step;
    logic [15:0]   r_dmag, n_dmag;
    logic [47:0]   r_quo, n_quo;

    logic          tk_we, lv_we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   tk_wdata, tk_rdata;
    logic [15:0]   lv_wdata, lv_rdata;

    bei_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_tick_ram (
        .i_clk(i_clk), .i_we(tk_we), .i_waddr(waddr), .i_wdata(tk_wdata),
        .i_raddr(raddr), .o_rdata(tk_rdata)
    );
    bei_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_level_ram (
        .i_clk(i_clk), .i_we(lv_we), .i_waddr(waddr), .i_wdata(lv_wdata),
        .i_raddr(raddr), .o_rdata(lv_rdata)
    );

    logic          accept;
    logic [CW-1:0] last_idx;
    logic [48:0]   rem_sh;
    logic [48:0]   rem_sub;
    logic signed [16:0] dy;

    assign accept   = i_start && (r_state == S_IDLE);
    assign last_idx = r_count - CW'(1);
    assign dy       = 17'($signed(lv_rdata)) - 17'(r_y0);
    assign rem_sh   = {r_rem, r_quo[47]};
    assign rem_sub  = rem_sh - {17'd0, r_dx};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd.command)
                        CMD_ADD:   n_state = (r_count == '0) ? S_INSERT : S_SCAN_RD;
                        CMD_EVAL:  n_state = (r_count == '0) ? S_ENDS_RD : S_EVAL_RD;
                        default:   n_state = S_ENDS_RD;
                    endcase
                end
            end
            S_SCAN_RD:  n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (tk_rdata == r_tick) begin
                    n_state = S_ENDS_RD;
                end else if (tk_rdata > r_tick || r_idx == last_idx) begin
                    n_state = (r_count == CW'(MAX_POINTS)) ? S_ENDS_RD :
                              ((tk_rdata > r_tick) ? S_SHIFT_RD : S_INSERT);
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: n_state = (r_idx == r_pos + CW'(1)) ? S_INSERT : S_SHIFT_RD;
            S_INSERT:   n_state = S_ENDS_RD;
            S_ENDS_RD:  n_state = S_ENDS_CHK;
            S_ENDS_CHK: n_state = (r_idx == last_idx || r_count == '0) ?
                                  S_DONE : S_ENDS_RD;
            S_EVAL_RD:  n_state = S_EVAL_CHK;
            S_EVAL_CHK: begin
                if (r_idx == '0) begin
                    n_state = (r_tick <= tk_rdata || r_idx == last_idx) ?
                              S_ENDS_RD : S_EVAL_RD;
                end else if (tk_rdata >= r_tick) begin
                    n_state = (tk_rdata == r_tick) ? S_ENDS_RD : S_MUL;
                end else begin
                    n_state = (r_idx == last_idx) ? S_ENDS_RD : S_EVAL_RD;
                end
            end
            S_MUL:  n_state = (r_step == 7'd31) ? S_DIV : S_MUL;
            S_DIV:  n_state = (r_step == 7'd47) ? S_ENDS_RD : S_DIV;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count = r_count; n_idx = r_idx; n_pos = r_pos; n_cmd = r_cmd;
        n_tick = r_tick; n_val = r_val; n_t0 = r_t0; n_y0 = r_y0;
        n_first = r_first; n_last = r_last; n_sample = r_sample;
        n_status = r_status; n_acc = r_acc; n_mcand = r_mcand; n_rem = r_rem;
        n_dx = r_dx; n_neg = r_neg; n_step = r_step; n_dmag = r_dmag;
        n_quo = r_quo;
        tk_we = 1'b0; lv_we = 1'b0;
        waddr = r_idx[AW-1:0]; raddr = r_idx[AW-1:0];
        tk_wdata = tk_rdata; lv_wdata = lv_rdata;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd = t_cmd'(i_cmd.command);
                    n_tick = i_cmd.tick;
                    n_val = i_cmd.value;
                    n_idx = '0;
                    n_sample = '0;
                    n_status = ST_OK;
                    n_first = '0;
                    n_last = '0;
                    n_pos = '0;
                    if (i_cmd.command == CMD_CLEAR) begin
                        n_count = '0;
                    end
                    if (i_cmd.command == CMD_EVAL && r_count == '0) begin
                        n_status = ST_EMPTY;
                    end
                end
            end
            S_SCAN_CHK: begin
                if (tk_rdata == r_tick) begin
                    lv_we = 1'b1; lv_wdata = r_val;
                    n_idx = '0;
                end else if (tk_rdata > r_tick || r_idx == last_idx) begin
                    if (r_count == CW'(MAX_POINTS)) begin
                        n_status = ST_FULL;
                        n_idx = '0;
                    end else if (tk_rdata > r_tick) begin
                        n_pos = r_idx;
                        n_idx = r_count;
                    end else begin
                        n_idx = r_count;
                    end
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_SHIFT_RD: raddr = AW'(r_idx - CW'(1));
            S_SHIFT_WR: begin
                tk_we = 1'b1; lv_we = 1'b1;
                n_idx = r_idx - CW'(1);
            end
            S_INSERT: begin
                tk_we = 1'b1; lv_we = 1'b1;
                tk_wdata = r_tick; lv_wdata = r_val;
                n_count = r_count + CW'(1);
                n_idx = '0;
            end
            S_ENDS_CHK: begin
                if (r_count != '0) begin
                    if (r_idx == '0) n_first = tk_rdata;
                    if (r_idx == last_idx) n_last = tk_rdata;
                end
                n_idx = last_idx;
            end
            S_EVAL_CHK: begin
                if (r_idx == '0) begin
                    if (r_tick < tk_rdata) begin
                        n_sample = r_hold ? lv_rdata : '0;
                    end else if (r_tick == tk_rdata) begin
                        n_sample = lv_rdata;
                    end else if (r_idx == last_idx) begin
                        n_sample = r_hold ? lv_rdata : '0;
                    end
                    n_t0 = tk_rdata; n_y0 = lv_rdata;
                    n_idx = (n_state == S_ENDS_RD) ? '0 : CW'(1);
                end else if (tk_rdata >= r_tick) begin
                    if (tk_rdata == r_tick) begin
                        n_sample = lv_rdata;
                        n_idx = '0;
                    end else begin
                        n_dx = tk_rdata - r_t0;
                        n_neg = dy[16];
                        n_dmag = dy[16] ? 16'(-dy) : dy[15:0];
                        n_mcand = r_tick - r_t0;
                        n_acc = '0;
                        n_step = '0;
                    end
                end else if (r_idx == last_idx) begin
                    n_sample = r_hold ? lv_rdata : '0;
                    n_idx = '0;
                end else begin
                    n_t0 = tk_rdata; n_y0 = lv_rdata;
                    n_idx = r_idx + CW'(1);
                end
            end
            S_MUL: begin
                n_acc = r_acc + (r_mcand[31 - r_step[4:0]] ?
                        {32'd0, r_dmag} << (31 - r_step[4:0]) : 48'd0);
                n_step = r_step + 7'd1;
                if (r_step == 7'd31) begin
                    n_quo = n_acc;
                    n_rem = '0;
                    n_step = '0;
                end
            end
            S_DIV: begin
                if (!rem_sub[48]) begin
                    n_rem = rem_sub[47:0];
                    n_quo = {r_quo[46:0], 1'b1};
                end else begin
                    n_rem = rem_sh[47:0];
                    n_quo = {r_quo[46:0], 1'b0};
                end
                n_step = r_step + 7'd1;
                if (r_step == 7'd47) begin
                    n_sample = r_neg ? 16'(r_y0 - $signed(n_quo[15:0])) :
                                       16'(r_y0 + $signed(n_quo[15:0]));
                    n_idx = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_hold  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) r_hold <= i_cfg_data;
        end
        r_idx <= n_idx; r_pos <= n_pos; r_cmd <= n_cmd; r_tick <= n_tick;
        r_val <= n_val; r_t0 <= n_t0; r_y0 <= n_y0; r_first <= n_first;
        r_last <= n_last; r_sample <= n_sample; r_status <= n_status;
        r_acc <= n_acc; r_mcand <= n_mcand; r_rem <= n_rem; r_dx <= n_dx;
        r_neg <= n_neg; r_step <= n_step; r_dmag <= n_dmag; r_quo <= n_quo;
    end

    always_comb begin
        o_busy = (r_state != S_IDLE);
        o_done = (r_state == S_DONE);
        o_cfg_ready = (r_state == S_IDLE);
        o_result.sample = (r_cmd == CMD_EVAL) ? r_sample : '0;
        o_result.status = r_status;
        o_result.first_tick = r_first;
        o_result.last_tick = r_last;
        o_result.span_defined = (r_count != '0) && !r_hold;
    end

`ifndef SYNTH
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS)) else $error("point count overflow");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done not a pulse");
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_EMPTY) |-> (r_count == '0))
        else $error("empty status with points");
`endif
endmodule
`default_nettype wire
